@@ hw/rtl/lru_size_bounded_cache_directory_macros.svh @@
// Assertion macros for the LRU cache directory.
`ifndef LRU_SIZE_BOUNDED_CACHE_DIRECTORY_MACROS_SVH
`define LRU_SIZE_BOUNDED_CACHE_DIRECTORY_MACROS_SVH
`ifndef SYNTHESIS
`define LRUCD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LRUCD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRUCD_ASSERT_IMP(label, ante, cons, msg)
`define LRUCD_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/lrucd_pkg.sv @@
// Shared types and constants of the LRU cache directory.
package lrucd_pkg;
	localparam int ENTRIES = 256;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 32;
	localparam int BYTES_W = 21;
	localparam int TAG_W   = 32;
	localparam int USED_W  = 24;
	localparam int SLOT_W  = 8;
	localparam int EVICT_W = 9;
	localparam int STAT_W  = 2;
	localparam logic [USED_W-1:0] CAP_RESET = USED_W'(1024 * 1024);

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_INSERTED = 2'd2,
		ST_REJECTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SW_KEY     = 3'd0,  // find slot holding the key
		SW_RANK    = 3'd1,  // find least recent slot
		SW_PROMOTE = 3'd2,
		SW_DEMOTE  = 3'd3,
		SW_AGE     = 3'd4   // age all entries, find lowest free slot
	} sweep_t;

	typedef struct packed {
		logic    load;
		logic    start;
		sweep_t  kind;
		logic    remove;
		logic    count_evict;
		logic    place;
		logic    set_res;
		status_t res_status;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic found;
		logic free_found;
		logic opcode;
		logic oversize;
		logic need_evict;
		logic out_free;
	} stat_t;
endpackage

@@ hw/rtl/lru_size_bounded_cache_directory.sv @@
// Top level of the size-bounded LRU cache directory.
// A directory of ENTRIES slots (256) with least-recently-used replacement and a
// byte capacity (reset 1 MiB, written through cfg_wr_en/cfg_wr_data; the user
// is to write it only while idle, which the block itself does not enforce).
// One transaction at a time: a lookup (opcode 0) or an insert (opcode 1) is taken
// on in_valid && in_ready and answered by exactly one result transaction. Keys,
// sizes, tags and recency ranks live in single-port-write RAMs with registered
// read, so every search or rank update is a sweep over all slots through the one
// RAM read port. Steps per transaction: a rejected insert runs no sweep; a lookup
// miss runs the search; a lookup hit runs the search, then a promote sweep; an
// insert runs the search, one sweep per key replacement, a check state and one
// sweep per LRU victim evicted, then an ageing sweep that also picks the lowest
// free slot. A stalled result register adds its stall to the result state.
// Valid bits sit in flops and clear at reset, so no clearing pass is needed. A
// finished result waits in the output register while the next transaction is
// already accepted.
`include "lru_size_bounded_cache_directory_macros.svh"
module lru_size_bounded_cache_directory import lrucd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [USED_W-1:0]   cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic [KEY_W-1:0]    key,
	input  logic [BYTES_W-1:0]  entry_bytes,
	input  logic [TAG_W-1:0]    data_tag,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   slot,
	output logic [TAG_W-1:0]    found_tag,
	output logic [EVICT_W-1:0]  evicted_count,
	output logic [USED_W-1:0]   used_bytes
);
	cmd_t  cmd;
	stat_t st;

	// sequencer: decides which sweep runs next
	lrucd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// storage, sweeper, occupancy and result register
	lrucd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.key           (key),
		.entry_bytes   (entry_bytes),
		.data_tag      (data_tag),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.status        (status),
		.slot          (slot),
		.found_tag     (found_tag),
		.evicted_count (evicted_count),
		.used_bytes    (used_bytes),
		.cmd           (cmd),
		.st            (st)
	);

	// one transaction in flight: acceptance closes the input
	`LRUCD_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken")
	// a sweep runs to its end before another is started
	`LRUCD_ASSERT_NXT(a_sweep_no_restart, cmd.start, !cmd.start, "sweep restarted")
	// a new entry goes only into a free slot the ageing sweep found
	`LRUCD_ASSERT_IMP(a_place_free, cmd.place, st.free_found, "no free slot on place")
	// removal needs a slot found by the preceding search
	`LRUCD_ASSERT_IMP(a_remove_found, cmd.remove, st.found, "remove without match")
endmodule

@@ hw/rtl/lrucd_ram.sv @@
// Generic RAM: one write port, one registered read port.
module lrucd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

@@ hw/rtl/lrucd_dp.sv @@
// Datapath: entry memories, valid bits, occupancy, slot sweeper, result register.
module lrucd_dp import lrucd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [USED_W-1:0]   cfg_wr_data,
	input  logic                opcode,
	input  logic [KEY_W-1:0]    key,
	input  logic [BYTES_W-1:0]  entry_bytes,
	input  logic [TAG_W-1:0]    data_tag,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   slot,
	output logic [TAG_W-1:0]    found_tag,
	output logic [EVICT_W-1:0]  evicted_count,
	output logic [USED_W-1:0]   used_bytes,
	input  cmd_t                cmd,
	output stat_t               st
);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic [USED_W-1:0]  cap_q, occ_q;
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TAG_W-1:0]   tag_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   count_q;
	logic [EVICT_W-1:0] evicted_q;

	logic               act_q, v_s1, last_s1, done_q;
	sweep_t             kind_q;
	logic [IDX_W-1:0]   idx_q, idx_s1;

	logic               found_q, free_found_q;
	logic [IDX_W-1:0]   f_idx_q, f_rank_q, free_q;
	logic [BYTES_W-1:0] f_size_q;
	logic [TAG_W-1:0]   f_tag_q;

	status_t            res_status_q;
	logic [SLOT_W-1:0]  res_slot_q;
	logic [TAG_W-1:0]   res_tag_q;
	logic               out_valid_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [SLOT_W-1:0]  out_slot_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic [EVICT_W-1:0] out_evict_q;
	logic [USED_W-1:0]  out_used_q;

	logic [KEY_W-1:0]   key_rd;
	logic [BYTES_W-1:0] size_rd;
	logic [TAG_W-1:0]   tag_rd;
	logic [IDX_W-1:0]   rank_rd;
	logic               rank_we;
	logic [IDX_W-1:0]   rank_wa, rank_wd, lru_rank;
	logic               ent_v, searching, hit;
	logic [USED_W:0]    need_sum;

	lrucd_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk(clk), .wr_en(cmd.place), .wr_addr(free_q), .wr_data(key_q),
		.rd_addr(idx_q), .rd_data(key_rd));
	lrucd_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_size_ram (
		.clk(clk), .wr_en(cmd.place), .wr_addr(free_q), .wr_data(bytes_q),
		.rd_addr(idx_q), .rd_data(size_rd));
	lrucd_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
		.clk(clk), .wr_en(cmd.place), .wr_addr(free_q), .wr_data(tag_q),
		.rd_addr(idx_q), .rd_data(tag_rd));
	lrucd_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
		.clk(clk), .wr_en(rank_we), .wr_addr(rank_wa), .wr_data(rank_wd),
		.rd_addr(idx_q), .rd_data(rank_rd));

	assign ent_v     = valid_q[idx_s1];
	assign lru_rank  = IDX_W'(count_q - 1'b1);
	assign searching = (kind_q == SW_KEY) || (kind_q == SW_RANK);
	assign hit       = v_s1 && searching && ent_v &&
		((kind_q == SW_KEY) ? (key_rd == key_q) : (rank_rd == lru_rank));
	assign need_sum  = {1'b0, occ_q} + (USED_W + 1)'(bytes_q);

	// rank update of the slot under the sweep, or the new entry's rank
	always_comb begin
		rank_we = 1'b0;
		rank_wa = idx_s1;
		rank_wd = rank_rd;
		if (cmd.place) begin
			rank_we = 1'b1;
			rank_wa = free_q;
			rank_wd = '0;
		end else if (v_s1 && ent_v) begin
			case (kind_q)
				SW_PROMOTE: begin
					if (idx_s1 == f_idx_q) begin
						rank_we = 1'b1;
						rank_wd = '0;
					end else if (rank_rd < f_rank_q) begin
						rank_we = 1'b1;
						rank_wd = IDX_W'(rank_rd + 1'b1);
					end
				end
				SW_DEMOTE: begin
					if (rank_rd > f_rank_q) begin
						rank_we = 1'b1;
						rank_wd = IDX_W'(rank_rd - 1'b1);
					end
				end
				SW_AGE: begin
					rank_we = 1'b1;
					rank_wd = IDX_W'(rank_rd + 1'b1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RESET;
			occ_q        <= '0;
			valid_q      <= '0;
			count_q      <= '0;
			evicted_q    <= '0;
			act_q        <= 1'b0;
			kind_q       <= SW_KEY;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			done_q       <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				act_q  <= 1'b1;
				kind_q <= cmd.kind;
				idx_q  <= '0;
			end else if (act_q) begin
				if (idx_q == LAST_IDX) begin
					act_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			v_s1    <= act_q;
			last_s1 <= act_q && (idx_q == LAST_IDX);
			done_q  <= v_s1 && last_s1;

			if (cmd.start && (cmd.kind == SW_KEY || cmd.kind == SW_RANK)) begin
				found_q <= 1'b0;
			end else if (hit) begin
				found_q <= 1'b1;
			end
			if (cmd.start && cmd.kind == SW_AGE) begin
				free_found_q <= 1'b0;
			end else if (v_s1 && kind_q == SW_AGE && !ent_v) begin
				free_found_q <= 1'b1;
			end

			if (cmd.load) begin
				evicted_q <= '0;
			end
			if (cmd.remove) begin
				valid_q[f_idx_q] <= 1'b0;
				occ_q            <= occ_q - USED_W'(f_size_q);
				count_q          <= count_q - 1'b1;
				if (cmd.count_evict) begin
					evicted_q <= evicted_q + 1'b1;
				end
			end
			if (cmd.place) begin
				valid_q[free_q] <= 1'b1;
				occ_q           <= occ_q + USED_W'(bytes_q);
				count_q         <= count_q + 1'b1;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			key_q   <= key;
			bytes_q <= entry_bytes;
			tag_q   <= data_tag;
		end
		idx_s1 <= idx_q;
		if (hit && !found_q) begin
			f_idx_q  <= idx_s1;
			f_rank_q <= rank_rd;
			f_size_q <= size_rd;
			f_tag_q  <= tag_rd;
		end
		if (v_s1 && kind_q == SW_AGE && !ent_v && !free_found_q) begin
			free_q <= idx_s1;
		end
		if (cmd.set_res) begin
			res_status_q <= cmd.res_status;
			case (cmd.res_status)
				ST_HIT: begin
					res_slot_q <= SLOT_W'(f_idx_q);
					res_tag_q  <= f_tag_q;
				end
				ST_INSERTED: begin
					res_slot_q <= SLOT_W'(free_q);
					res_tag_q  <= '0;
				end
				default: begin
					res_slot_q <= '0;
					res_tag_q  <= '0;
				end
			endcase
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_tag_q    <= res_tag_q;
			out_evict_q  <= evicted_q;
			out_used_q   <= occ_q;
		end
	end

	assign st.sweep_done = done_q;
	assign st.found      = found_q;
	assign st.free_found = free_found_q;
	assign st.opcode     = op_q;
	assign st.oversize   = {3'b000, bytes_q} > cap_q;
	assign st.need_evict = (count_q != '0) &&
		((need_sum > {1'b0, cap_q}) || (count_q == CNT_W'(ENTRIES)));
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign slot          = out_slot_q;
	assign found_tag     = out_tag_q;
	assign evicted_count = out_evict_q;
	assign used_bytes    = out_used_q;
endmodule

@@ hw/rtl/lrucd_ctrl.sv @@
// Controller: sequences searches, rank sweeps, evictions and the result.
module lrucd_ctrl import lrucd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t st,
	output cmd_t  cmd
);
	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_START   = 9'b000000010,
		S_SRCH    = 9'b000000100,
		S_PROMOTE = 9'b000001000,
		S_DEMOTE  = 9'b000010000,
		S_CHECK   = 9'b000100000,
		S_EVICT   = 9'b001000000,
		S_AGE     = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (st.opcode == OP_INSERT && st.oversize) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_REJECTED;
					state_d        = S_RESP;
				end else begin
					cmd.start = 1'b1;
					cmd.kind  = SW_KEY;
					state_d   = S_SRCH;
				end
			end
			S_SRCH: begin
				if (st.sweep_done) begin
					if (st.opcode == OP_LOOKUP) begin
						if (st.found) begin
							cmd.start = 1'b1;
							cmd.kind  = SW_PROMOTE;
							state_d   = S_PROMOTE;
						end else begin
							cmd.set_res    = 1'b1;
							cmd.res_status = ST_MISS;
							state_d        = S_RESP;
						end
					end else if (st.found) begin
						cmd.remove = 1'b1;
						cmd.start  = 1'b1;
						cmd.kind   = SW_DEMOTE;
						state_d    = S_DEMOTE;
					end else begin
						state_d = S_CHECK;
					end
				end
			end
			S_PROMOTE: begin
				if (st.sweep_done) begin
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_HIT;
					state_d        = S_RESP;
				end
			end
			S_DEMOTE: begin
				if (st.sweep_done) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.start = 1'b1;
				if (st.need_evict) begin
					cmd.kind = SW_RANK;
					state_d  = S_EVICT;
				end else begin
					cmd.kind = SW_AGE;
					state_d  = S_AGE;
				end
			end
			S_EVICT: begin
				if (st.sweep_done) begin
					cmd.remove      = 1'b1;
					cmd.count_evict = 1'b1;
					state_d         = S_CHECK;
				end
			end
			S_AGE: begin
				if (st.sweep_done) begin
					cmd.place      = 1'b1;
					cmd.set_res    = 1'b1;
					cmd.res_status = ST_INSERTED;
					state_d        = S_RESP;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ dv/lru_size_bounded_cache_directory_tb.sv @@
// Self-checking testbench for the size-bounded LRU cache directory.
module lru_size_bounded_cache_directory_tb import lrucd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 8_000_000;

	typedef struct packed {
		status_t            st;
		logic [SLOT_W-1:0]  slot;
		logic [TAG_W-1:0]   tag;
		logic [EVICT_W-1:0] evicted;
		logic [USED_W-1:0]  used;
	} dir_result_t;

	// one row of the directed table; typed rows carry a hand-worked answer
	typedef struct packed {
		logic               op;
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] nbytes;
		logic [TAG_W-1:0]   tag;
		logic               typed;
		dir_result_t        res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [USED_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_LOOKUP;
	logic [KEY_W-1:0] key = '0;
	logic [BYTES_W-1:0] entry_bytes = '0;
	logic [TAG_W-1:0] data_tag = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot;
	logic [TAG_W-1:0] found_tag;
	logic [EVICT_W-1:0] evicted_count;
	logic [USED_W-1:0] used_bytes;

	lru_size_bounded_cache_directory DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .key(key), .entry_bytes(entry_bytes), .data_tag(data_tag),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .slot(slot), .found_tag(found_tag),
		.evicted_count(evicted_count), .used_bytes(used_bytes)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------------
	// Directory shadow: our own copy of slots, ranks, occupancy and capacity
	// ---------------------------------------------------------------------
	logic               sh_valid [ENTRIES];
	logic [KEY_W-1:0]   sh_key   [ENTRIES];
	logic [BYTES_W-1:0] sh_size  [ENTRIES];
	logic [TAG_W-1:0]   sh_tag   [ENTRIES];
	int unsigned        sh_rank  [ENTRIES];
	logic [USED_W-1:0]  sh_used;
	logic [USED_W-1:0]  sh_capacity;

	dir_result_t expected_q[$];
	logic        row_typed = 1'b0;
	dir_result_t row_res;
	int unsigned n_errors = 0;
	int unsigned n_results = 0;
	int unsigned n_hits = 0;
	int unsigned n_evicts = 0;
	int unsigned n_rejects = 0;
	int unsigned cycles = 0;

	// drop a slot and close the gap in the recency ranks
	function automatic void drop_slot(int s);
		int unsigned r;
		r = sh_rank[s];
		sh_valid[s] = 1'b0;
		sh_used = sh_used - USED_W'(sh_size[s]);
		for (int i = 0; i < ENTRIES; i++)
			if (sh_valid[i] && sh_rank[i] > r)
				sh_rank[i]--;
	endfunction

	function automatic dir_result_t predict_directory(logic op, logic [KEY_W-1:0] k,
			logic [BYTES_W-1:0] b, logic [TAG_W-1:0] t);
		dir_result_t r;
		int hit;
		int victim;
		int nvalid;
		int unsigned ev;
		r = '0;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && sh_valid[i] && sh_key[i] == k)
				hit = i;
		if (op == OP_LOOKUP) begin
			if (hit >= 0) begin
				for (int i = 0; i < ENTRIES; i++)
					if (sh_valid[i] && sh_rank[i] < sh_rank[hit])
						sh_rank[i]++;
				sh_rank[hit] = 0;
				r.st = ST_HIT;
				r.slot = SLOT_W'(hit);
				r.tag = sh_tag[hit];
			end else begin
				r.st = ST_MISS;
			end
		end else if (USED_W'(b) > sh_capacity) begin
			// oversized: nothing moves, not even a same-key entry
			r.st = ST_REJECTED;
		end else begin
			if (hit >= 0)
				drop_slot(hit);
			ev = 0;
			forever begin
				nvalid = 0;
				victim = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (sh_valid[i]) begin
						nvalid++;
						if (victim < 0 || sh_rank[i] > sh_rank[victim])
							victim = i;
					end
				if (!(25'(sh_used) + 25'(b) > 25'(sh_capacity) || nvalid >= ENTRIES))
					break;
				if (victim < 0)
					break;
				drop_slot(victim);
				ev++;
			end
			hit = 0;
			while (hit < ENTRIES && sh_valid[hit])
				hit++;
			for (int i = 0; i < ENTRIES; i++)
				if (sh_valid[i])
					sh_rank[i]++;
			sh_valid[hit] = 1'b1;
			sh_key[hit] = k;
			sh_size[hit] = b;
			sh_tag[hit] = t;
			sh_rank[hit] = 0;
			sh_used = sh_used + USED_W'(b);
			r.st = ST_INSERTED;
			r.slot = SLOT_W'(hit);
			r.evicted = EVICT_W'(ev);
		end
		r.used = sh_used;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Monitor. Inputs and DUT outputs only move at the rising edge, so the
	// falling edge shows exactly what the next rising edge will accept.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		dir_result_t p;
		dir_result_t e;
		if (arst_n && in_valid && in_ready) begin
			p = predict_directory(opcode, key, entry_bytes, data_tag);
			expected_q.push_back(row_typed ? row_res : p);
		end
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("ERROR: result transaction with nothing outstanding");
			end else begin
				e = expected_q.pop_front();
				if (status != e.st || slot != e.slot || found_tag != e.tag ||
						evicted_count != e.evicted || used_bytes != e.used) begin
					n_errors++;
					if (n_errors <= 10)
						$display({"ERROR: result %0d exp st=%0d slot=%0d tag=%h ev=%0d ",
							"used=%0d, got st=%0d slot=%0d tag=%h ev=%0d used=%0d"},
							n_results, e.st, e.slot, e.tag, e.evicted, e.used,
							status, slot, found_tag, evicted_count, used_bytes);
				end
				if (e.st == ST_HIT) n_hits++;
				if (e.st == ST_REJECTED) n_rejects++;
				n_evicts += e.evicted;
			end
		end
	end

	// receiver stalls: long ready stretches, short and occasional long stalls
	initial begin
		int n;
		forever begin
			@(posedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_q.size());
			$display("FAIL lru_size_bounded_cache_directory");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Driver. Called at a rising edge; returns at the edge that accepts.
	// ---------------------------------------------------------------------
	task automatic send(logic op, logic [KEY_W-1:0] k, logic [BYTES_W-1:0] b,
			logic [TAG_W-1:0] t, logic typed, dir_result_t res);
		int gap;
		gap = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 60) :
			($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		entry_bytes <= b;
		data_tag <= t;
		row_typed = typed;
		row_res = res;
		do @(negedge clk); while (!(in_valid && in_ready));
		@(posedge clk);
	endtask

	// quiet the input, let every outstanding result drain, then write capacity
	task automatic set_capacity(logic [USED_W-1:0] c);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		sh_capacity = c;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic dir_result_t mk(status_t st, int unsigned s, logic [TAG_W-1:0] t,
			int unsigned ev, int unsigned u);
		dir_result_t r;
		r.st = st;
		r.slot = SLOT_W'(s);
		r.tag = t;
		r.evicted = EVICT_W'(ev);
		r.used = USED_W'(u);
		return r;
	endfunction

	dir_row_t directed_rows[$];

	task automatic add_row(logic op, logic [KEY_W-1:0] k, logic [BYTES_W-1:0] b,
			logic [TAG_W-1:0] t, logic typed, dir_result_t res);
		dir_row_t r;
		r.op = op;
		r.key = k;
		r.nbytes = b;
		r.tag = t;
		r.typed = typed;
		r.res = res;
		directed_rows.push_back(r);
	endtask

	// key pool kept small so lookups and reinserts hit often
	function automatic logic [KEY_W-1:0] pick_key(int pool);
		return ($urandom_range(0, 19) == 0) ? KEY_W'($urandom()) :
			KEY_W'($urandom_range(0, pool));
	endfunction

	function automatic logic [BYTES_W-1:0] pick_bytes(logic [USED_W-1:0] cap);
		int unsigned sel;
		int unsigned hi;
		sel = $urandom_range(0, 19);
		hi = (cap > 24'h1FFFFF) ? 32'h1FFFFF : int'(cap);
		if (sel == 0) return '0;
		if (sel == 1) return '1;
		if (sel == 2) return BYTES_W'($urandom());
		if (sel == 3) return BYTES_W'(hi);
		if (sel == 4 && hi < 32'h1FFFFF) return BYTES_W'(hi + 1);
		return BYTES_W'($urandom_range(0, (hi / 3 > 0) ? hi / 3 : hi));
	endfunction

	initial begin
		logic [USED_W-1:0] caps [6];
		dir_result_t none;
		int per_phase;
		logic op;

		none = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			sh_valid[i] = 1'b0;
			sh_rank[i] = 0;
		end
		sh_used = '0;
		sh_capacity = CAP_RESET;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-worked opening from reset, capacity 1 MiB
		add_row(OP_LOOKUP, 32'h0, 21'h0, 32'h0, 1, mk(ST_MISS, 0, 0, 0, 0));
		add_row(OP_INSERT, 32'h0, 21'h0, 32'h0, 1, mk(ST_INSERTED, 0, 0, 0, 0));
		add_row(OP_INSERT, 32'hFFFF_FFFF, 21'd1048576, 32'hFFFF_FFFF, 1,
			mk(ST_INSERTED, 1, 0, 0, 1048576));
		add_row(OP_LOOKUP, 32'hFFFF_FFFF, 21'h0, 32'h1234, 1,
			mk(ST_HIT, 1, 32'hFFFF_FFFF, 0, 1048576));
		add_row(OP_INSERT, 32'h7, 21'h1F_FFFF, 32'h1, 1, mk(ST_REJECTED, 0, 0, 0, 1048576));
		add_row(OP_INSERT, 32'hFFFF_FFFF, 21'd1048577, 32'h2, 1,
			mk(ST_REJECTED, 0, 0, 0, 1048576));
		add_row(OP_LOOKUP, 32'h0, 21'h1F_FFFF, 32'h0, 1, mk(ST_HIT, 0, 0, 0, 1048576));
		// full capacity: the least recent (big) entry has to go
		add_row(OP_INSERT, 32'h9, 21'h1, 32'h5A5A_A5A5, 1, mk(ST_INSERTED, 1, 0, 1, 1));
		// same key again replaces the old entry without counting an eviction
		add_row(OP_INSERT, 32'h9, 21'd100, 32'h1, 1, mk(ST_INSERTED, 1, 0, 0, 100));
		add_row(OP_LOOKUP, 32'h9, 21'h0, 32'h0, 0, none);
		add_row(OP_INSERT, 32'h0, 21'h0A_AAAA, 32'hAAAA_AAAA, 0, none);
		add_row(OP_INSERT, 32'h5555_5555, 21'h05_5555, 32'h5555_5555, 0, none);
		add_row(OP_LOOKUP, 32'hAAAA_AAAA, 21'h0, 32'h0, 0, none);
		add_row(OP_LOOKUP, 32'h5555_5555, 21'h0, 32'h0, 0, none);
		add_row(OP_INSERT, 32'h3, 21'h0, 32'h3, 0, none);
		add_row(OP_LOOKUP, 32'h0, 21'h0, 32'h0, 0, none);
		add_row(OP_INSERT, 32'h8000_0000, 21'h10_0000, 32'h8000_0001, 0, none);
		foreach (directed_rows[i])
			send(directed_rows[i].op, directed_rows[i].key, directed_rows[i].nbytes,
				directed_rows[i].tag, directed_rows[i].typed, directed_rows[i].res);

		// fill past the slot count with tiny entries so the count bound evicts
		set_capacity(24'hFF_FFFF);
		for (int i = 0; i < 300; i++)
			send(OP_INSERT, KEY_W'(32'h1000 + i), BYTES_W'($urandom_range(0, 7)),
				$urandom(), 0, none);
		for (int i = 0; i < 20; i++)
			send(OP_LOOKUP, KEY_W'(32'h1000 + $urandom_range(0, 299)), '0, '0, 0, none);
		// capacity below occupancy: lookups leave it, the next insert evicts
		set_capacity(24'd0);
		send(OP_LOOKUP, 32'h1100, '0, '0, 0, none);
		send(OP_INSERT, 32'h42, '0, 32'h42, 0, none);
		send(OP_INSERT, 32'h43, 21'h1, 32'h43, 0, none);

		// random phases over a spread of capacities
		caps[0] = 24'd4096;
		caps[1] = 24'd300;
		caps[2] = CAP_RESET;
		caps[3] = 24'd0;
		caps[4] = 24'hFF_FFFF;
		caps[5] = 24'd2_500_000;
		per_phase = 210;
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			for (int i = 0; i < per_phase; i++) begin
				op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_INSERT;
				send(op, pick_key(40), op == OP_INSERT ? pick_bytes(caps[p]) :
					BYTES_W'($urandom()), $urandom(), 0, none);
			end
		end

		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);

		$display("covered %0d results: %0d hits, %0d rejected inserts, %0d LRU evictions",
			n_results, n_hits, n_rejects, n_evicts);
		$display("capacity swept through 0, 300, 4096, 1 MiB, 2.5 MB and full scale");
		if (n_errors == 0 && expected_q.size() == 0) begin
			$display("PASS lru_size_bounded_cache_directory");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("FAIL lru_size_bounded_cache_directory");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lrucd_pkg.sv
hw/rtl/lrucd_ram.sv
hw/rtl/lrucd_dp.sv
hw/rtl/lrucd_ctrl.sv
hw/rtl/lru_size_bounded_cache_directory.sv
dv/lru_size_bounded_cache_directory_tb.sv
